FILE: hw/rtl/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Shared types, command codes and size constants for the sequencer.
// ----------------------------------------------------------------------------
package snfcs_pkg;

    localparam int unsigned PAGE_BYTES_DEF   = 256;
    localparam int unsigned SECTOR_BYTES_DEF = 4096;
    localparam int unsigned MAX_RESULTS      = 6;
    localparam int unsigned CFG_IDX_W        = 3;
    localparam int unsigned CFG_DATA_W       = 25;

    localparam logic [7:0] CMD_STATUS  = 8'h05;
    localparam logic [7:0] CMD_WREN    = 8'h06;
    localparam logic [7:0] CMD_READ    = 8'h03;
    localparam logic [7:0] CMD_PROGRAM = 8'h02;
    localparam logic [7:0] CMD_SECTOR  = 8'h20;
    localparam logic [7:0] CMD_CHIP    = 8'hC7;
    localparam logic [7:0] CMD_ID      = 8'h9F;

    typedef enum logic [2:0] {
        ACT_READ   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_WDATA  = 3'd2,
        ACT_SECTOR = 3'd3,
        ACT_CHIP   = 3'd4,
        ACT_ID     = 3'd5,
        ACT_FLASH  = 3'd6,
        ACT_TICK   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        K_SEND   = 2'd0,
        K_SLOT   = 2'd1,
        K_HOST   = 2'd2,
        K_STATUS = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD     = 3'd1,
        ST_RANGE   = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_MAKER   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY = 3'd0,
        REG_BUSY_TO  = 3'd1,
        REG_ERASE_TO = 3'd2,
        REG_CHIP_TO  = 3'd3,
        REG_MAKER    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] op_address;
        logic [24:0] op_length;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_last;
        logic [2:0] done_status;
        logic       last;
    } t_out_item;

endpackage

FILE: hw/rtl/spi_nor_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns host requests and flash events into framed SPI bytes and statuses.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one transaction per request or event (read, write,
// data byte, sector erase, chip erase, read ID, flash byte in, tick). Each
// input transaction causes zero to five result transactions on the output
// channel, the final one flagged by last.
// An accepted transaction is held in an input register; once the result
// buffer is free the sequencer state is updated and up to five results are
// written to the result buffer in one step. The buffer then drains one result
// per cycle while the receiver does not stall, and the drain of the result
// buffer sets the pace. A new transaction can wait in the input register while
// the results of the last one drain. When the receiver stalls, the current
// result holds and the input side is stalled once the input register and
// result buffer are both full.
// Reset clears the configuration to its defaults, puts the sequencer idle and
// empties both registers. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_top #(
    parameter int unsigned PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = snfcs_pkg::SECTOR_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  snfcs_pkg::t_in_item                 i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output snfcs_pkg::t_out_item                o_data,
    input  logic                                i_cfg_we,
    input  logic [snfcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [snfcs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import snfcs_pkg::*;

    localparam int unsigned PG_W  = $clog2(PAGE_BYTES);
    localparam int unsigned SEC_W = $clog2(SECTOR_BYTES);

    typedef enum logic [3:0] {
        PH_IDLE, PH_READ, PH_POLL, PH_WDATA, PH_ERASED, PH_ID
    } t_phase;

    localparam logic [1:0] PP_WRITE = 2'd0, PP_PRE = 2'd1, PP_SECT = 2'd2, PP_CHIP = 2'd3;
    localparam logic [17:0] ELAPSED_MAX = 18'h3FFFF;

    // Configuration registers
    logic [24:0] r_capacity;
    logic [15:0] r_busy_to;
    logic [16:0] r_erase_to;
    logic [17:0] r_chip_to;
    logic [7:0]  r_maker;

    // Sequencer state
    t_phase      r_phase, n_phase;
    logic [23:0] r_addr, n_addr;
    logic [24:0] r_rem, n_rem;
    logic [PG_W:0] r_chunk, n_chunk;
    logic [17:0] r_elapsed, n_elapsed;
    logic [2:0]  r_op, n_op;
    logic [1:0]  r_pp, n_pp;
    logic [1:0]  r_idx, n_idx;
    logic        r_match, n_match;

    // Input register and result buffer
    logic        r_in_vld;
    t_in_item    r_in;
    t_out_item   r_res [MAX_RESULTS];
    t_out_item   n_res [MAX_RESULTS];
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_rd;

    logic buf_busy, buf_free, step, in_acc, out_acc;

    assign out_acc  = o_valid && !i_stall;
    assign buf_busy = (r_cnt != 3'd0);
    // Buffer is free this cycle if empty or its final result leaves now.
    assign buf_free = !buf_busy || (out_acc && (r_rd == r_cnt - 3'd1));
    assign step     = r_in_vld && buf_free;
    assign o_stall  = r_in_vld && !step;
    assign in_acc   = i_valid && !o_stall;
    assign o_valid  = buf_busy;
    assign o_data   = r_res[r_rd];

    always_comb begin
        logic [2:0]  act;
        logic [7:0]  b;
        logic [17:0] lim;
        logic [25:0] span;
        logic [PG_W:0] avail;
        logic [2:0]  k;
        logic [1:0]  idx1;

        act  = r_in.action;
        b    = r_in.data_byte;
        k    = 3'd0;
        lim  = 18'd0;
        span = 26'd0;
        avail = '0;
        idx1 = 2'd0;
        n_phase = r_phase; n_addr = r_addr; n_rem = r_rem; n_chunk = r_chunk;
        n_elapsed = r_elapsed; n_op = r_op; n_pp = r_pp; n_idx = r_idx;
        n_match = r_match;
        for (int i = 0; i < MAX_RESULTS; i++) n_res[i] = '0;

        case (act)
            ACT_TICK: begin
                if (r_elapsed < ELAPSED_MAX) n_elapsed = r_elapsed + 18'd1;
                if (r_phase == PH_ERASED) begin
                    n_pp = PP_SECT; n_elapsed = 18'd0;
                    n_res[0] = '{K_SEND, CMD_STATUS, 1'b1, 1'b0, ST_OK, 1'b0};
                    n_res[1] = '{K_SLOT, 8'd0, 1'b0, 1'b1, ST_OK, 1'b0};
                    k = 3'd2; n_phase = PH_POLL;
                end
            end
            ACT_FLASH: begin
                if (r_phase == PH_POLL) begin
                    if (!b[0]) begin
                        case (r_pp)
                            PP_WRITE: begin
                                if (r_rem != 25'd0) begin
                                    avail = (PG_W+1)'(PAGE_BYTES)
                                          - {1'b0, r_addr[PG_W-1:0]};
                                    n_chunk = (r_rem < 25'(avail)) ? (PG_W+1)'(r_rem) : avail;
                                    n_res[0] = '{K_SEND, CMD_WREN, 1'b1, 1'b1, ST_OK, 1'b0};
                                    n_res[1] = '{K_SEND, CMD_PROGRAM, 1'b1, 1'b0, ST_OK, 1'b0};
                                    n_res[2] = '{K_SEND, r_addr[23:16], 1'b0, 1'b0, ST_OK, 1'b0};
                                    n_res[3] = '{K_SEND, r_addr[15:8], 1'b0, 1'b0, ST_OK, 1'b0};
                                    n_res[4] = '{K_SEND, r_addr[7:0], 1'b0, 1'b0, ST_OK, 1'b0};
                                    k = 3'd5; n_phase = PH_WDATA;
                                end else begin
                                    n_res[0] = '{K_STATUS, 8'd0, 1'b0, 1'b0, ST_OK, 1'b0};
                                    k = 3'd1; n_phase = PH_IDLE;
                                end
                            end
                            PP_PRE: begin
                                n_res[0] = '{K_SEND, CMD_WREN, 1'b1, 1'b1, ST_OK, 1'b0};
                                if (r_op == ACT_CHIP) begin
                                    n_res[1] = '{K_SEND, CMD_CHIP, 1'b1, 1'b1, ST_OK, 1'b0};
                                    n_res[2] = '{K_SEND, CMD_STATUS, 1'b1, 1'b0, ST_OK, 1'b0};
                                    n_res[3] = '{K_SLOT, 8'd0, 1'b0, 1'b1, ST_OK, 1'b0};
                                    k = 3'd4; n_pp = PP_CHIP; n_elapsed = 18'd0;
                                    n_phase = PH_POLL;
                                end else begin
                                    n_res[1] = '{K_SEND, CMD_SECTOR, 1'b1, 1'b0, ST_OK, 1'b0};
                                    n_res[2] = '{K_SEND, r_addr[23:16], 1'b0, 1'b0, ST_OK, 1'b0};
                                    n_res[3] = '{K_SEND, r_addr[15:8], 1'b0, 1'b0, ST_OK, 1'b0};
                                    n_res[4] = '{K_SEND, r_addr[7:0], 1'b0, 1'b1, ST_OK, 1'b0};
                                    k = 3'd5; n_phase = PH_ERASED;
                                end
                            end
                            default: begin
                                n_res[0] = '{K_STATUS, 8'd0, 1'b0, 1'b0, ST_OK, 1'b0};
                                k = 3'd1; n_phase = PH_IDLE;
                            end
                        endcase
                    end else begin
                        lim = (r_pp == PP_WRITE) ? 18'(r_busy_to)
                            : (r_pp == PP_CHIP) ? r_chip_to : 18'(r_erase_to);
                        if (r_elapsed >= lim) begin
                            n_res[0] = '{K_STATUS, 8'd0, 1'b0, 1'b0, ST_TIMEOUT, 1'b0};
                            k = 3'd1; n_phase = PH_IDLE;
                        end else begin
                            n_res[0] = '{K_SEND, CMD_STATUS, 1'b1, 1'b0, ST_OK, 1'b0};
                            n_res[1] = '{K_SLOT, 8'd0, 1'b0, 1'b1, ST_OK, 1'b0};
                            k = 3'd2;
                        end
                    end
                end else if (r_phase == PH_READ) begin
                    n_res[0] = '{K_HOST, b, 1'b0, 1'b0, ST_OK, 1'b0};
                    n_rem = r_rem - 25'd1;
                    if (n_rem == 25'd0) begin
                        n_res[1] = '{K_STATUS, 8'd0, 1'b0, 1'b0, ST_OK, 1'b0};
                        n_phase = PH_IDLE;
                    end else begin
                        n_res[1] = '{K_SLOT, 8'd0, 1'b0, n_rem == 25'd1, ST_OK, 1'b0};
                    end
                    k = 3'd2;
                end else if (r_phase == PH_ID) begin
                    n_res[0] = '{K_HOST, b, 1'b0, 1'b0, ST_OK, 1'b0};
                    if (r_idx == 2'd0) n_match = (b == r_maker);
                    idx1 = r_idx + 2'd1;
                    n_idx = idx1;
                    if (idx1 != 2'd3) begin
                        n_res[1] = '{K_SLOT, 8'd0, 1'b0, idx1 == 2'd2, ST_OK, 1'b0};
                    end else begin
                        n_res[1] = '{K_STATUS, 8'd0, 1'b0, 1'b0,
                                     n_match ? ST_OK : ST_MAKER, 1'b0};
                        n_phase = PH_IDLE;
                    end
                    k = 3'd2;
                end
            end
            ACT_WDATA: begin
                if (r_phase == PH_WDATA) begin
                    n_res[0] = '{K_SEND, b, 1'b0, r_chunk <= (PG_W+1)'(1), ST_OK, 1'b0};
                    k = 3'd1;
                    if (r_chunk != '0) n_chunk = r_chunk - (PG_W+1)'(1);
                    if (r_rem != 25'd0) n_rem = r_rem - 25'd1;
                    n_addr = r_addr + 24'd1;
                    if (n_chunk == '0) begin
                        n_pp = PP_WRITE; n_elapsed = 18'd0;
                        n_res[1] = '{K_SEND, CMD_STATUS, 1'b1, 1'b0, ST_OK, 1'b0};
                        n_res[2] = '{K_SLOT, 8'd0, 1'b0, 1'b1, ST_OK, 1'b0};
                        k = 3'd3; n_phase = PH_POLL;
                    end
                end
            end
            default: begin
                if (r_phase == PH_IDLE) begin
                    n_op = act;
                    span = {2'b0, r_in.op_address} + {1'b0, r_in.op_length};
                    if (act == ACT_READ || act == ACT_WRITE) begin
                        if (r_in.op_length == 25'd0) begin
                            n_res[0] = '{K_STATUS, 8'd0, 1'b0, 1'b0, ST_BAD, 1'b0};
                            k = 3'd1;
                        end else if (span > {1'b0, r_capacity}) begin
                            n_res[0] = '{K_STATUS, 8'd0, 1'b0, 1'b0, ST_RANGE, 1'b0};
                            k = 3'd1;
                        end else begin
                            n_addr = r_in.op_address; n_rem = r_in.op_length;
                            if (act == ACT_READ) begin
                                n_res[0] = '{K_SEND, CMD_READ, 1'b1, 1'b0, ST_OK, 1'b0};
                                n_res[1] = '{K_SEND, r_in.op_address[23:16], 1'b0, 1'b0,
                                             ST_OK, 1'b0};
                                n_res[2] = '{K_SEND, r_in.op_address[15:8], 1'b0, 1'b0,
                                             ST_OK, 1'b0};
                                n_res[3] = '{K_SEND, r_in.op_address[7:0], 1'b0, 1'b0,
                                             ST_OK, 1'b0};
                                n_res[4] = '{K_SLOT, 8'd0, 1'b0, r_in.op_length == 25'd1,
                                             ST_OK, 1'b0};
                                k = 3'd5; n_phase = PH_READ;
                            end else begin
                                n_chunk = '0; n_pp = PP_WRITE; n_elapsed = 18'd0;
                                n_res[0] = '{K_SEND, CMD_STATUS, 1'b1, 1'b0, ST_OK, 1'b0};
                                n_res[1] = '{K_SLOT, 8'd0, 1'b0, 1'b1, ST_OK, 1'b0};
                                k = 3'd2; n_phase = PH_POLL;
                            end
                        end
                    end else if (act == ACT_SECTOR &&
                                 (r_in.op_address[SEC_W-1:0] != '0 ||
                                  {1'b0, r_in.op_address} >= r_capacity)) begin
                        n_res[0] = '{K_STATUS, 8'd0, 1'b0, 1'b0, ST_RANGE, 1'b0};
                        k = 3'd1;
                    end else if (act == ACT_SECTOR || act == ACT_CHIP) begin
                        if (act == ACT_SECTOR) n_addr = r_in.op_address;
                        n_pp = PP_PRE; n_elapsed = 18'd0;
                        n_res[0] = '{K_SEND, CMD_STATUS, 1'b1, 1'b0, ST_OK, 1'b0};
                        n_res[1] = '{K_SLOT, 8'd0, 1'b0, 1'b1, ST_OK, 1'b0};
                        k = 3'd2; n_phase = PH_POLL;
                    end else begin
                        n_idx = 2'd0; n_match = 1'b0;
                        n_res[0] = '{K_SEND, CMD_ID, 1'b1, 1'b0, ST_OK, 1'b0};
                        n_res[1] = '{K_SLOT, 8'd0, 1'b0, 1'b0, ST_OK, 1'b0};
                        k = 3'd2; n_phase = PH_ID;
                    end
                end
            end
        endcase
        n_cnt = k;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (3'(i + 1) == k) n_res[i].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 25'd8388608;
            r_busy_to  <= 16'd1000;
            r_erase_to <= 17'd5000;
            r_chip_to  <= 18'd120000;
            r_maker    <= 8'd239;
            r_phase    <= PH_IDLE;
            r_addr     <= '0;
            r_rem      <= '0;
            r_chunk    <= '0;
            r_elapsed  <= '0;
            r_op       <= '0;
            r_pp       <= '0;
            r_idx      <= '0;
            r_match    <= 1'b0;
            r_in_vld   <= 1'b0;
            r_cnt      <= '0;
            r_rd       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_CAPACITY: r_capacity <= i_cfg_data;
                    REG_BUSY_TO:  r_busy_to  <= i_cfg_data[15:0];
                    REG_ERASE_TO: r_erase_to <= i_cfg_data[16:0];
                    REG_CHIP_TO:  r_chip_to  <= i_cfg_data[17:0];
                    REG_MAKER:    r_maker    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_in_vld <= 1'b1;
                r_in     <= i_data;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step) begin
                r_phase <= n_phase; r_addr <= n_addr; r_rem <= n_rem;
                r_chunk <= n_chunk; r_elapsed <= n_elapsed; r_op <= n_op;
                r_pp <= n_pp; r_idx <= n_idx; r_match <= n_match;
                r_cnt <= n_cnt; r_rd <= '0;
                r_res <= n_res;
            end else if (out_acc) begin
                if (r_rd == r_cnt - 3'd1) begin
                    r_cnt <= '0;
                    r_rd  <= '0;
                end else begin
                    r_rd <= r_rd + 3'd1;
                end
            end
        end
    end

    // A new batch only lands when the previous one has fully drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> (r_cnt == 3'd0 || out_acc))
        else $error("result buffer overwritten");
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_rd < r_cnt))
        else $error("read pointer beyond result count");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last == (r_rd == r_cnt - 3'd1)))
        else $error("last flag misplaced");

endmodule

FILE: dv/spi_nor_flash_command_sequencer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// Drives requests and flash events into the sequencer, reacting to its state
// so that reads, page-split writes, erases, read ID and busy polls run through
// to completion. A local model of the sequencer predicts every result
// transaction, and each one the block hands out is checked field by field.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_top_test;
    import snfcs_pkg::*;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_READ, SEQ_POLL, SEQ_WDATA, SEQ_ERASED, SEQ_ID
    } t_seq_phase;

    typedef enum logic [1:0] {
        POLL_WRITE, POLL_PRE_ERASE, POLL_POST_SECTOR, POLL_POST_CHIP
    } t_poll_kind;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned IN_W           = $bits(t_in_item);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_data;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    spi_nor_flash_command_sequencer_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Configuration copy and sequencer state of the local model
    logic [24:0] cap_bytes;
    logic [15:0] busy_limit;
    logic [16:0] erase_limit;
    logic [17:0] chip_limit;
    logic [7:0]  maker_id;

    t_seq_phase  seq_phase;
    logic [23:0] addr_ptr;
    logic [24:0] bytes_left;
    logic [8:0]  chunk_left;
    logic [17:0] elapsed;
    logic [2:0]  op_kind;
    t_poll_kind  poll_kind;
    logic [1:0]  id_index;
    logic        maker_ok;

    t_out_item   expected_results[$];
    t_out_item   step_results[$];

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned status_seen[8];
    int unsigned idle_cycles;
    bit          quiet;

    // ---------------- prediction ----------------
    function automatic void emit(t_kind kind, logic [7:0] b, logic ff, logic fl,
                                 t_status st);
        t_out_item r;
        r.out_kind    = kind;
        r.out_byte    = b;
        r.frame_first = ff;
        r.frame_last  = fl;
        r.done_status = st;
        r.last        = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void complete(t_status st);
        emit(K_STATUS, 8'h00, 1'b0, 1'b0, st);
        seq_phase = SEQ_IDLE;
    endfunction

    function automatic void send_cmd_addr(logic [7:0] cmd, logic [23:0] a);
        emit(K_SEND, cmd, 1'b1, 1'b0, ST_OK);
        emit(K_SEND, a[23:16], 1'b0, 1'b0, ST_OK);
        emit(K_SEND, a[15:8], 1'b0, 1'b0, ST_OK);
        emit(K_SEND, a[7:0], 1'b0, 1'b0, ST_OK);
    endfunction

    function automatic void status_frame();
        emit(K_SEND, CMD_STATUS, 1'b1, 1'b0, ST_OK);
        emit(K_SLOT, 8'h00, 1'b0, 1'b1, ST_OK);
        seq_phase = SEQ_POLL;
    endfunction

    function automatic void begin_poll(t_poll_kind k);
        poll_kind = k;
        elapsed   = '0;
        status_frame();
    endfunction

    function automatic logic [17:0] current_limit();
        if (poll_kind == POLL_WRITE) return {2'b00, busy_limit};
        if (poll_kind == POLL_POST_CHIP) return chip_limit;
        return {1'b0, erase_limit};
    endfunction

    function automatic void begin_page_chunk();
        logic [24:0] room;
        room = 25'(PAGE_BYTES_DEF - (addr_ptr % PAGE_BYTES_DEF));
        chunk_left = 9'((bytes_left < room) ? bytes_left : room);
        emit(K_SEND, CMD_WREN, 1'b1, 1'b1, ST_OK);
        send_cmd_addr(CMD_PROGRAM, addr_ptr);
        seq_phase = SEQ_WDATA;
    endfunction

    function automatic void flash_ready();
        case (poll_kind)
            POLL_WRITE: begin
                if (bytes_left > 0) begin_page_chunk();
                else complete(ST_OK);
            end
            POLL_PRE_ERASE: begin
                emit(K_SEND, CMD_WREN, 1'b1, 1'b1, ST_OK);
                if (op_kind == ACT_CHIP) begin
                    emit(K_SEND, CMD_CHIP, 1'b1, 1'b1, ST_OK);
                    begin_poll(POLL_POST_CHIP);
                end else begin
                    emit(K_SEND, CMD_SECTOR, 1'b1, 1'b0, ST_OK);
                    emit(K_SEND, addr_ptr[23:16], 1'b0, 1'b0, ST_OK);
                    emit(K_SEND, addr_ptr[15:8], 1'b0, 1'b0, ST_OK);
                    emit(K_SEND, addr_ptr[7:0], 1'b0, 1'b1, ST_OK);
                    seq_phase = SEQ_ERASED;
                end
            end
            default: complete(ST_OK);
        endcase
    endfunction

    function automatic bit span_ok(logic [23:0] a, logic [24:0] len);
        if (len == 0) begin
            complete(ST_BAD);
            return 1'b0;
        end
        if ({2'b00, a} + {1'b0, len} > {1'b0, cap_bytes}) begin
            complete(ST_RANGE);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void flash_byte_in(logic [7:0] b);
        case (seq_phase)
            SEQ_POLL: begin
                if (!b[0]) flash_ready();
                else if (elapsed >= current_limit()) complete(ST_TIMEOUT);
                else status_frame();
            end
            SEQ_READ: begin
                emit(K_HOST, b, 1'b0, 1'b0, ST_OK);
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) complete(ST_OK);
                else emit(K_SLOT, 8'h00, 1'b0, bytes_left == 1, ST_OK);
            end
            SEQ_ID: begin
                emit(K_HOST, b, 1'b0, 1'b0, ST_OK);
                if (id_index == 0) maker_ok = (b == maker_id);
                id_index = id_index + 1'b1;
                if (id_index < 3) emit(K_SLOT, 8'h00, 1'b0, id_index == 2, ST_OK);
                else complete(maker_ok ? ST_OK : ST_MAKER);
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_sequencer(t_in_item it);
        t_out_item r;
        step_results.delete();
        case (t_action'(it.action))
            ACT_TICK: begin
                if (elapsed != 18'h3FFFF) elapsed = elapsed + 1'b1;
                if (seq_phase == SEQ_ERASED) begin_poll(POLL_POST_SECTOR);
            end
            ACT_FLASH: flash_byte_in(it.data_byte);
            ACT_WDATA: begin
                if (seq_phase == SEQ_WDATA) begin
                    emit(K_SEND, it.data_byte, 1'b0, chunk_left <= 1, ST_OK);
                    if (chunk_left > 0) chunk_left = chunk_left - 1'b1;
                    if (bytes_left > 0) bytes_left = bytes_left - 1'b1;
                    addr_ptr = addr_ptr + 1'b1;
                    if (chunk_left == 0) begin_poll(POLL_WRITE);
                end
            end
            default: begin
                if (seq_phase == SEQ_IDLE) begin
                    op_kind = it.action;
                    case (t_action'(it.action))
                        ACT_READ: begin
                            if (span_ok(it.op_address, it.op_length)) begin
                                addr_ptr   = it.op_address;
                                bytes_left = it.op_length;
                                send_cmd_addr(CMD_READ, it.op_address);
                                emit(K_SLOT, 8'h00, 1'b0, it.op_length == 1, ST_OK);
                                seq_phase = SEQ_READ;
                            end
                        end
                        ACT_WRITE: begin
                            if (span_ok(it.op_address, it.op_length)) begin
                                addr_ptr   = it.op_address;
                                bytes_left = it.op_length;
                                chunk_left = '0;
                                begin_poll(POLL_WRITE);
                            end
                        end
                        ACT_SECTOR: begin
                            if ((it.op_address % SECTOR_BYTES_DEF) != 0 ||
                                {1'b0, it.op_address} >= cap_bytes) begin
                                complete(ST_RANGE);
                            end else begin
                                addr_ptr = it.op_address;
                                begin_poll(POLL_PRE_ERASE);
                            end
                        end
                        ACT_CHIP: begin_poll(POLL_PRE_ERASE);
                        default: begin
                            id_index = '0;
                            maker_ok = 1'b0;
                            emit(K_SEND, CMD_ID, 1'b1, 1'b0, ST_OK);
                            emit(K_SLOT, 8'h00, 1'b0, 1'b0, ST_OK);
                            seq_phase = SEQ_ID;
                        end
                    endcase
                end
            end
        endcase
        for (int k = 0; k < step_results.size(); k++) begin
            r = step_results[k];
            r.last = (k == step_results.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    // ---------------- driving ----------------
    task automatic send_item(t_in_item it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        predict_sequencer(it);
        items_sent++;
    endtask

    function automatic t_in_item make_item(t_action a, logic [23:0] addr,
                                           logic [24:0] len, logic [7:0] b);
        t_in_item it;
        it.action     = a;
        it.op_address = addr;
        it.op_length  = len;
        it.data_byte  = b;
        return it;
    endfunction

    task automatic send_event(t_action a, logic [7:0] b);
        send_item(make_item(a, 24'($urandom), 25'($urandom), b));
    endtask

    task automatic send_request(t_action a, logic [23:0] addr, logic [24:0] len);
        send_item(make_item(a, addr, len, 8'($urandom)));
    endtask

    // Waits until every predicted result has come out and the pipeline is empty.
    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg_idx idx, logic [24:0] value);
        drain_and_settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_CAPACITY: cap_bytes   = value;
            REG_BUSY_TO:  busy_limit  = value[15:0];
            REG_ERASE_TO: erase_limit = value[16:0];
            REG_CHIP_TO:  chip_limit  = value[17:0];
            default:      maker_id    = value[7:0];
        endcase
    endtask

    // Sends the event the sequencer is waiting for, after random ticks in a poll;
    // busy_pct sets how often a status poll is answered with the busy bit set.
    task automatic answer_flash(int unsigned busy_pct);
        logic [7:0] b;
        b = 8'($urandom);
        case (seq_phase)
            SEQ_POLL: begin
                if ($urandom_range(0, 99) < 20)
                    repeat ($urandom_range(1, 3)) send_event(ACT_TICK, 8'($urandom));
                b[0] = ($urandom_range(0, 99) < busy_pct);
                send_event(ACT_FLASH, b);
            end
            SEQ_ERASED: send_event(ACT_TICK, b);
            SEQ_WDATA:  send_event(ACT_WDATA, b);
            SEQ_ID: begin
                if (id_index == 0 && $urandom_range(0, 1)) b = maker_id;
                send_event(ACT_FLASH, b);
            end
            default: send_event(ACT_FLASH, b);
        endcase
    endtask

    task automatic finish_operation(int unsigned busy_pct);
        while (seq_phase != SEQ_IDLE) answer_flash(busy_pct);
    endtask

    task automatic random_request();
        logic [23:0] addr;
        logic [24:0] len;
        t_action     a;
        a    = t_action'($urandom_range(0, 5));
        // A long length always overruns the capacity, so a read or write with it is only ever rejected.
        if ($urandom_range(0, 9) == 0)
            len = cap_bytes + 25'($urandom_range(1, 255));
        else
            len = 25'($urandom_range(1, (a == ACT_WRITE) ? 20 : 6));
        addr = 24'($urandom);
        if ($urandom_range(0, 9) != 0 && cap_bytes >= len)
            addr = 24'($urandom_range(0, cap_bytes - len));
        if (a == ACT_WRITE && $urandom_range(0, 1)) begin
            addr[7:0] = 8'hF8 + 8'($urandom_range(0, 7));
        end
        if (a == ACT_SECTOR && $urandom_range(0, 9) != 0)
            addr = 24'($urandom_range(0, (cap_bytes - 1) / SECTOR_BYTES_DEF)
                       * SECTOR_BYTES_DEF);
        send_request(a, addr, len);
    endtask

    // ---------------- tests ----------------
    task automatic test_request_checks();
        send_request(ACT_READ, 24'h000000, 25'd0);
        send_request(ACT_WRITE, 24'hFFFFFF, 25'h1FFFFFF);
        send_request(ACT_READ, 24'h7FFFFF, 25'd2);
        send_request(ACT_SECTOR, 24'h000800, 25'd0);
        send_request(ACT_SECTOR, 24'h800000, 25'd0);
        send_event(ACT_WDATA, 8'hFF);
        send_event(ACT_FLASH, 8'h00);
        send_event(ACT_TICK, 8'h00);
    endtask

    task automatic test_operations();
        send_request(ACT_READ, 24'h7FFFFF, 25'd1);
        finish_operation(0);
        send_request(ACT_READ, 24'h000000, 25'd3);
        send_request(ACT_CHIP, 24'h0, 25'd0);
        send_event(ACT_FLASH, 8'hFF);
        finish_operation(0);
        send_request(ACT_WRITE, 24'h0000FE, 25'd4);
        send_event(ACT_FLASH, 8'h01);
        finish_operation(0);
        send_request(ACT_SECTOR, 24'h7FF000, 25'd0);
        finish_operation(0);
        send_request(ACT_CHIP, 24'h0, 25'd0);
        finish_operation(0);
        send_request(ACT_ID, 24'h0, 25'd0);
        send_event(ACT_FLASH, 8'd239);
        finish_operation(0);
        send_request(ACT_ID, 24'h0, 25'd0);
        send_event(ACT_FLASH, 8'h00);
        finish_operation(0);
    endtask

    task automatic test_busy_timeouts();
        write_register(REG_BUSY_TO, 25'd1);
        write_register(REG_ERASE_TO, 25'd1);
        write_register(REG_CHIP_TO, 25'd1);
        send_request(ACT_WRITE, 24'h000010, 25'd2);
        send_event(ACT_FLASH, 8'h01);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_FLASH, 8'hFF);
        send_request(ACT_CHIP, 24'h0, 25'd0);
        send_event(ACT_FLASH, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_FLASH, 8'h01);
    endtask

    task automatic random_traffic(int unsigned n, int unsigned busy_pct);
        int unsigned stop_at;
        t_in_item    junk;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                junk = t_in_item'(IN_W'({$urandom, $urandom}));
                // Any read or write among these overruns the capacity and is rejected.
                junk.op_length[24] = 1'b1;
                junk.op_length[0]  = 1'b1;
                send_item(junk);
            end else begin
                random_request();
                finish_operation(busy_pct);
            end
        end
        finish_operation(0);
    endtask

    task automatic test_config_extremes();
        write_register(REG_CAPACITY, 25'd1);
        write_register(REG_MAKER, 25'h00);
        random_traffic(15, 40);
        write_register(REG_CAPACITY, 25'h1000000);
        write_register(REG_BUSY_TO, 25'd65535);
        write_register(REG_ERASE_TO, 25'd131071);
        write_register(REG_CHIP_TO, 25'd262143);
        write_register(REG_MAKER, 25'hFF);
        random_traffic(35, 30);
        write_register(REG_CAPACITY, 25'h0012345);
        write_register(REG_BUSY_TO, 25'd2);
        write_register(REG_ERASE_TO, 25'd3);
        write_register(REG_CHIP_TO, 25'd2);
        write_register(REG_MAKER, 25'hA5);
        random_traffic(45, 50);
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_out_item want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_data));
            end else begin
                want = expected_results.pop_front();
                if (o_data !== want)
                    report_mismatch($sformatf("got %p, wanted %p", o_data, want));
                if (o_data.out_kind == K_STATUS) status_seen[o_data.done_status]++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts
    int unsigned stall_left;
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(1, 16);
        end else begin
            i_stall    <= 1'b0;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_CAPACITY;
        i_cfg_data = '0;
        quiet      = 1'b0;
        cap_bytes   = 25'd8388608;
        busy_limit  = 16'd1000;
        erase_limit = 17'd5000;
        chip_limit  = 18'd120000;
        maker_id    = 8'd239;
        seq_phase   = SEQ_IDLE;
        addr_ptr    = '0;
        bytes_left  = '0;
        chunk_left  = '0;
        elapsed     = '0;
        op_kind     = '0;
        poll_kind   = POLL_WRITE;
        id_index    = '0;
        maker_ok    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_request_checks();
        test_operations();
        test_busy_timeouts();
        test_config_extremes();
        write_register(REG_BUSY_TO, 25'd4);
        write_register(REG_ERASE_TO, 25'd5);
        write_register(REG_CAPACITY, 25'd8388608);
        random_traffic(35, 25);
        quiet = 1'b1;
        random_traffic(30, 25);

        drain_and_settle();
        $display("Sent %0d transactions, checked %0d results", items_sent, results_seen);
        $display("Statuses ok/bad/range/timeout/maker: %0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: spi_nor_flash_command_sequencer_top.f
hw/rtl/snfcs_pkg.sv
hw/rtl/spi_nor_flash_command_sequencer_top.sv
dv/spi_nor_flash_command_sequencer_top_test.sv
